@@ design/uart_fifo_status_controller_assert.svh @@
// Assertion macros used by the checker file design/ufsc_checker.sv.
`ifndef UART_FIFO_STATUS_CONTROLLER_ASSERT_SVH
`define UART_FIFO_STATUS_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UFSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ufsc checker: property failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UFSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ufsc checker: property failed");

`endif

@@ design/ufsc_pkg.sv @@
package ufsc_pkg;

    // Queue geometry
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int LEVEL_W    = 5;
    localparam int LEVEL_CAP  = 16;

    // Stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 2;

    // Status flag bit positions
    localparam int FLAG_TEND = 0;
    localparam int FLAG_DR   = 1;
    localparam int FLAG_TDFE = 2;
    localparam int FLAG_RDF  = 3;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [2:0] {
        OP_LINE_RX     = 3'd0,
        OP_LINE_READY  = 3'd1,
        OP_TX_WRITE    = 3'd2,
        OP_RX_READ     = 3'd3,
        OP_STAT_READ   = 3'd4,
        OP_STAT_WRITE  = 3'd5,
        OP_COUNT_READ  = 3'd6,
        OP_RECHECK     = 3'd7
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TX_IRQ_EN   = 3'd0,
        REG_RX_IRQ_EN   = 3'd1,
        REG_TX_EN       = 3'd2,
        REG_RX_TRIG_SEL = 3'd3,
        REG_TX_TRIG_SEL = 3'd4,
        REG_RX_FIFO_RST = 3'd5,
        REG_TX_FIFO_RST = 3'd6
    } reg_idx_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_stall;
    } dp_status_t;

    // Receive trigger level: 1, 4, 8, 14 bytes
    function automatic cnt_t rx_trig_level(input logic [1:0] sel);
        cnt_t lvl;
        case (sel)
            2'd0:    lvl = cnt_t'(1);
            2'd1:    lvl = cnt_t'(4);
            2'd2:    lvl = cnt_t'(8);
            default: lvl = cnt_t'(14);
        endcase
        return lvl;
    endfunction

    // Transmit trigger level: 8, 4, 2, 1 bytes
    function automatic cnt_t tx_trig_level(input logic [1:0] sel);
        cnt_t lvl;
        case (sel)
            2'd0:    lvl = cnt_t'(8);
            2'd1:    lvl = cnt_t'(4);
            2'd2:    lvl = cnt_t'(2);
            default: lvl = cnt_t'(1);
        endcase
        return lvl;
    endfunction

    // Circular pointer advance, wraps at the queue depth
    function automatic ptr_t ptr_add(input ptr_t base, input cnt_t off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(FIFO_DEPTH))
            sum = sum - (CNT_W+1)'(FIFO_DEPTH);
        return sum[PTR_W-1:0];
    endfunction

    // Reported level, saturated
    function automatic logic [LEVEL_W-1:0] level_of(input cnt_t c);
        logic [LEVEL_W-1:0] lvl;
        if (32'(c) > LEVEL_CAP)
            lvl = LEVEL_W'(LEVEL_CAP);
        else
            lvl = LEVEL_W'(c);
        return lvl;
    endfunction

endpackage

@@ design/ufsc_ctrl.sv @@
module ufsc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  ufsc_pkg::dp_status_t  status,
    output ufsc_pkg::ctrl_cmd_t   cmd
);

    ufsc_pkg::state_t state_reg;
    ufsc_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ufsc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ufsc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ufsc_pkg::ST_EXEC;
            end
            ufsc_pkg::ST_EXEC:
            begin
                if (!status.out_stall)
                    state_next = ufsc_pkg::ST_IDLE;
            end
            default: state_next = ufsc_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            ufsc_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ufsc_pkg::ST_EXEC:
            begin
                cmd.execute = !status.out_stall;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ design/ufsc_datapath.sv @@
module ufsc_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ufsc_pkg::ctrl_cmd_t                    cmd,
    output ufsc_pkg::dp_status_t                   status,
    input  logic [2:0]                             in_opcode,
    input  logic [7:0]                             in_byte,
    input  logic [3:0]                             in_new_flags,
    input  logic                                   cfg_we,
    input  logic [ufsc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ufsc_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [ufsc_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    // Configuration registers
    logic       tx_irq_en_reg;
    logic       rx_irq_en_reg;
    logic       tx_en_reg;
    logic [1:0] rx_trig_sel_reg;
    logic [1:0] tx_trig_sel_reg;
    logic       rx_fifo_rst_reg;
    logic       tx_fifo_rst_reg;

    // Captured request
    ufsc_pkg::op_t opcode_reg;
    logic [7:0]    byte_reg;
    logic [3:0]    new_flags_reg;

    // Queue state
    logic [7:0]     rx_mem [ufsc_pkg::FIFO_DEPTH];
    logic [7:0]     tx_mem [ufsc_pkg::FIFO_DEPTH];
    logic [7:0]     rx_rdata_reg;
    logic [7:0]     tx_rdata_reg;
    ufsc_pkg::ptr_t rx_head_reg, rx_head_next;
    ufsc_pkg::ptr_t tx_head_reg, tx_head_next;
    ufsc_pkg::cnt_t rx_count_reg, rx_count_next;
    ufsc_pkg::cnt_t tx_count_reg, tx_count_next;
    logic [3:0]     flags_reg, flags_next;
    logic [3:0]     marks_reg, marks_next;

    // Output register
    logic                               out_valid_reg, out_valid_next;
    logic [ufsc_pkg::OUT_TDATA_W-1:0]   out_data_reg;

    // Event results
    logic           rx_wr_en, tx_wr_en;
    ufsc_pkg::ptr_t rx_wr_ptr, tx_wr_ptr;
    ufsc_pkg::cnt_t rx_trig, tx_trig;
    ufsc_pkg::cnt_t rx_cnt_tmp, tx_cnt_tmp;
    logic [3:0]     keep_cond;
    logic [3:0]     nv;
    logic [7:0]     rd_byte;
    logic           lo_valid;
    logic [7:0]     lo_byte;
    logic           rirq, tirq;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_irq_en_reg   <= 1'b0;
            rx_irq_en_reg   <= 1'b0;
            tx_en_reg       <= 1'b0;
            rx_trig_sel_reg <= 2'd0;
            tx_trig_sel_reg <= 2'd0;
            rx_fifo_rst_reg <= 1'b0;
            tx_fifo_rst_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (ufsc_pkg::reg_idx_t'(cfg_index))
                ufsc_pkg::REG_TX_IRQ_EN:   tx_irq_en_reg   <= cfg_data[0];
                ufsc_pkg::REG_RX_IRQ_EN:   rx_irq_en_reg   <= cfg_data[0];
                ufsc_pkg::REG_TX_EN:       tx_en_reg       <= cfg_data[0];
                ufsc_pkg::REG_RX_TRIG_SEL: rx_trig_sel_reg <= cfg_data[1:0];
                ufsc_pkg::REG_TX_TRIG_SEL: tx_trig_sel_reg <= cfg_data[1:0];
                ufsc_pkg::REG_RX_FIFO_RST: rx_fifo_rst_reg <= cfg_data[0];
                ufsc_pkg::REG_TX_FIFO_RST: tx_fifo_rst_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            opcode_reg    <= ufsc_pkg::op_t'(in_opcode);
            byte_reg      <= in_byte;
            new_flags_reg <= in_new_flags;
        end
    end

    // Queue memories: head read at capture, push written at execute
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rx_rdata_reg <= rx_mem[rx_head_reg];
            tx_rdata_reg <= tx_mem[tx_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && rx_wr_en)
            rx_mem[rx_wr_ptr] <= byte_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && tx_wr_en)
            tx_mem[tx_wr_ptr] <= byte_reg;
    end

    // Event execution
    always_comb
    begin
        rx_trig       = ufsc_pkg::rx_trig_level(rx_trig_sel_reg);
        tx_trig       = ufsc_pkg::tx_trig_level(tx_trig_sel_reg);
        rx_head_next  = rx_head_reg;
        tx_head_next  = tx_head_reg;
        rx_count_next = rx_count_reg;
        tx_count_next = tx_count_reg;
        flags_next    = flags_reg;
        marks_next    = marks_reg;
        rx_wr_en      = 1'b0;
        tx_wr_en      = 1'b0;
        rx_wr_ptr     = ufsc_pkg::ptr_add(rx_head_reg, rx_count_reg);
        tx_wr_ptr     = ufsc_pkg::ptr_add(tx_head_reg, tx_count_reg);
        rx_cnt_tmp    = rx_count_reg;
        tx_cnt_tmp    = tx_count_reg;
        rd_byte       = 8'd0;
        lo_valid      = 1'b0;
        lo_byte       = 8'd0;
        rirq          = 1'b0;
        tirq          = 1'b0;
        nv            = new_flags_reg;
        keep_cond[ufsc_pkg::FLAG_TEND] = (tx_count_reg == '0);
        keep_cond[ufsc_pkg::FLAG_DR]   = (rx_count_reg < rx_trig);
        keep_cond[ufsc_pkg::FLAG_TDFE] = (tx_count_reg <= tx_trig);
        keep_cond[ufsc_pkg::FLAG_RDF]  = (rx_count_reg >= rx_trig);

        case (opcode_reg)
            ufsc_pkg::OP_LINE_RX:
            begin
                if (rx_count_reg < ufsc_pkg::cnt_t'(ufsc_pkg::FIFO_DEPTH))
                begin
                    rx_wr_en   = 1'b1;
                    rx_cnt_tmp = rx_count_reg + ufsc_pkg::cnt_t'(1);
                end
                if (rx_cnt_tmp >= rx_trig)
                    flags_next[ufsc_pkg::FLAG_DR] = 1'b0;
                if (rx_fifo_rst_reg)
                begin
                    rx_head_next = '0;
                    rx_cnt_tmp   = '0;
                    flags_next[ufsc_pkg::FLAG_DR] = 1'b1;
                end
                if (rx_cnt_tmp >= rx_trig)
                begin
                    flags_next[ufsc_pkg::FLAG_RDF] = 1'b1;
                    rirq = rx_irq_en_reg;
                end
                rx_count_next = rx_cnt_tmp;
            end
            ufsc_pkg::OP_LINE_READY:
            begin
                if (tx_fifo_rst_reg)
                begin
                    // flushed queue has nothing to send
                    tx_head_next  = '0;
                    tx_count_next = '0;
                    flags_next[ufsc_pkg::FLAG_TEND] = 1'b1;
                end
                else if (tx_count_reg != '0)
                begin
                    lo_valid      = 1'b1;
                    lo_byte       = tx_rdata_reg;
                    tx_head_next  = ufsc_pkg::ptr_add(tx_head_reg, ufsc_pkg::cnt_t'(1));
                    tx_cnt_tmp    = tx_count_reg - ufsc_pkg::cnt_t'(1);
                    tx_count_next = tx_cnt_tmp;
                    if (tx_cnt_tmp <= tx_trig)
                    begin
                        flags_next[ufsc_pkg::FLAG_TDFE] = 1'b1;
                        tirq = tx_irq_en_reg;
                    end
                end
                else
                begin
                    flags_next[ufsc_pkg::FLAG_TEND] = 1'b1;
                end
            end
            ufsc_pkg::OP_TX_WRITE:
            begin
                if (tx_count_reg < ufsc_pkg::cnt_t'(ufsc_pkg::FIFO_DEPTH))
                begin
                    tx_wr_en      = 1'b1;
                    tx_count_next = tx_count_reg + ufsc_pkg::cnt_t'(1);
                end
            end
            ufsc_pkg::OP_RX_READ:
            begin
                if (rx_count_reg != '0)
                begin
                    rd_byte       = rx_rdata_reg;
                    rx_head_next  = ufsc_pkg::ptr_add(rx_head_reg, ufsc_pkg::cnt_t'(1));
                    rx_cnt_tmp    = rx_count_reg - ufsc_pkg::cnt_t'(1);
                    rx_count_next = rx_cnt_tmp;
                    if (rx_cnt_tmp >= rx_trig)
                    begin
                        flags_next[ufsc_pkg::FLAG_DR] = 1'b1;
                        marks_next[ufsc_pkg::FLAG_DR] = 1'b0;
                    end
                end
            end
            ufsc_pkg::OP_STAT_READ:
            begin
                marks_next = marks_reg | flags_reg;
            end
            ufsc_pkg::OP_STAT_WRITE:
            begin
                // a cleared flag that was read while set holds while its condition does
                for (int i = 0; i < 4; i++)
                begin
                    if (!nv[i] && flags_reg[i] && marks_reg[i] && keep_cond[i])
                        nv[i] = 1'b1;
                end
                flags_next = nv;
            end
            ufsc_pkg::OP_COUNT_READ:
            begin
                flags_next = flags_reg;
            end
            ufsc_pkg::OP_RECHECK:
            begin
                if (rx_count_reg >= rx_trig)
                begin
                    flags_next[ufsc_pkg::FLAG_RDF] = 1'b1;
                    rirq = rx_irq_en_reg;
                end
                if (tx_count_reg <= tx_trig)
                begin
                    flags_next[ufsc_pkg::FLAG_TDFE] = 1'b1;
                    tirq = tx_irq_en_reg;
                end
                if (rx_fifo_rst_reg)
                begin
                    rx_head_next  = '0;
                    rx_count_next = '0;
                    flags_next[ufsc_pkg::FLAG_DR] = 1'b1;
                end
                if (tx_fifo_rst_reg)
                begin
                    tx_head_next  = '0;
                    tx_count_next = '0;
                end
                if (!tx_en_reg)
                    flags_next[ufsc_pkg::FLAG_TEND] = 1'b1;
            end
            default:
            begin
                flags_next = flags_reg;
            end
        endcase
    end

    // Queue pointers, counts, flags and read marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg  <= '0;
            tx_head_reg  <= '0;
            rx_count_reg <= '0;
            tx_count_reg <= '0;
            flags_reg    <= '0;
            marks_reg    <= '0;
        end
        else if (cmd.execute)
        begin
            rx_head_reg  <= rx_head_next;
            tx_head_reg  <= tx_head_next;
            rx_count_reg <= rx_count_next;
            tx_count_reg <= tx_count_next;
            flags_reg    <= flags_next;
            marks_reg    <= marks_next;
        end
    end

    // Result register
    always_comb
    begin
        if (cmd.execute)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            out_data_reg <= {
                7'd0,
                tirq,
                rirq,
                lo_byte,
                lo_valid,
                flags_next[ufsc_pkg::FLAG_RDF],
                flags_next[ufsc_pkg::FLAG_TDFE],
                flags_next[ufsc_pkg::FLAG_DR],
                flags_next[ufsc_pkg::FLAG_TEND],
                ufsc_pkg::level_of(tx_count_next),
                ufsc_pkg::level_of(rx_count_next),
                rd_byte
            };
        end
    end

    assign status.out_stall = out_valid_reg && !m_tready;
    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_data_reg;

endmodule

@@ design/uart_fifo_status_controller.sv @@
// Channel | Dir | Handshake          | Payload
// s       | in  | s_tvalid/s_tready  | s_tuser opcode, s_tdata event data and flag values
// m       | out | m_tvalid/m_tready  | m_tdata read byte, levels, flags, line byte, irqs
// cfg     | in  | cfg_we             | cfg_index register index, cfg_data value
//
// Each request passes through an accept state that reads both queue memories at their
// heads into registered read data, and an execute state that updates pointers, counts,
// flags and loads the result register. The next request is accepted the cycle after execute.
// A request may be accepted while a result waits; execute then holds until m_tready.
// rst_n clears configuration, pointers, counts, flags and read marks; queue memories
// keep their contents.
module uart_fifo_status_controller
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [7:0] byte_value, [8] new_tend, [9] new_dr, [10] new_tdfe, [11] new_rdf,
    // [15:12] zero
    input  logic [ufsc_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [2:0] opcode
    input  logic [ufsc_pkg::IN_TUSER_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] read_byte, [12:8] rx_level, [17:13] tx_level, [18] flag_tend,
    // [19] flag_dr, [20] flag_tdfe, [21] flag_rdf, [22] line_out_valid,
    // [30:23] line_out_byte, [31] rx_irq, [32] tx_irq, [39:33] zero
    output logic [ufsc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_we,
    input  logic [ufsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ufsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    ufsc_pkg::ctrl_cmd_t  cmd;
    ufsc_pkg::dp_status_t status;

    ufsc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ufsc_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_opcode    (s_tuser[2:0]),
        .in_byte      (s_tdata[7:0]),
        .in_new_flags (s_tdata[11:8]),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

@@ design/ufsc_checker.sv @@
`include "uart_fifo_status_controller_assert.svh"

module ufsc_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [ufsc_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    // a stalled result holds
    `UFSC_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one request at a time: no accept right after an accept
    `UFSC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // levels never pass the queue depth
    `UFSC_ASSERT_IMP(a_level_cap, m_tvalid,
        (m_tdata[12:8] <= 5'd16) && (m_tdata[17:13] <= 5'd16))

    // interrupts come with their flags; idle line byte is zero
    `UFSC_ASSERT_IMP(a_irq_flags, m_tvalid,
        (!m_tdata[31] || m_tdata[21]) && (!m_tdata[32] || m_tdata[20]) &&
        (m_tdata[22] || (m_tdata[30:23] == 8'd0)))

endmodule

bind uart_fifo_status_controller ufsc_checker u_ufsc_checker (.*);

@@ tb/sv/uart_fifo_status_checker.sv @@
`timescale 1ns / 100ps

module uart_fifo_status_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    // [7:0] byte_value, [8] new_tend, [9] new_dr, [10] new_tdfe, [11] new_rdf,
    // [15:12] zero
    input  logic [ufsc_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [2:0] opcode
    input  logic [ufsc_pkg::IN_TUSER_W-1:0]      s_tuser,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] read_byte, [12:8] rx_level, [17:13] tx_level, [18] flag_tend,
    // [19] flag_dr, [20] flag_tdfe, [21] flag_rdf, [22] line_out_valid,
    // [30:23] line_out_byte, [31] rx_irq, [32] tx_irq, [39:33] zero
    input  logic [ufsc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_we,
    input  logic [ufsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ufsc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                   mismatch_count,
    output int                                   results_owed
);

    import ufsc_pkg::*;

    // Result word, laid out as on m_tdata (msb first)
    typedef struct packed {
        logic [6:0] pad;
        logic       tx_irq;
        logic       rx_irq;
        logic [7:0] line_byte;
        logic       line_valid;
        logic       rdf;
        logic       tdfe;
        logic       dr;
        logic       tend;
        logic [4:0] tx_level;
        logic [4:0] rx_level;
        logic [7:0] read_byte;
    } fifo_event_result_t;

    int rx_trig_tbl [4] = '{1, 4, 8, 14};
    int tx_trig_tbl [4] = '{8, 4, 2, 1};

    // Predicted queue and flag state
    logic [7:0] rx_mem [FIFO_DEPTH];
    logic [7:0] tx_mem [FIFO_DEPTH];
    int         rx_head;
    int         rx_cnt;
    int         tx_head;
    int         tx_cnt;
    logic [3:0] flags;
    logic [3:0] read_marks;

    // Predicted register copy
    logic       tx_irq_en;
    logic       rx_irq_en;
    logic       tx_en;
    logic [1:0] rx_trig_sel;
    logic [1:0] tx_trig_sel;
    logic       rx_flush;
    logic       tx_flush;

    fifo_event_result_t awaited_results [$];
    fifo_event_result_t want;
    fifo_event_result_t got;
    fifo_event_result_t fresh;
    string              diff;
    int                 result_no;

    initial
    begin
        mismatch_count = 0;
        results_owed   = 0;
        result_no      = 0;
    end

    // RDF raise when rx count reaches its trigger; returns the irq bit
    function automatic logic rx_level_check();
        if (rx_cnt >= rx_trig_tbl[rx_trig_sel])
        begin
            flags[FLAG_RDF] = 1'b1;
            return rx_irq_en;
        end
        return 1'b0;
    endfunction

    // TDFE raise when tx count is at or below its trigger
    function automatic logic tx_level_check();
        if (tx_cnt <= tx_trig_tbl[tx_trig_sel])
        begin
            flags[FLAG_TDFE] = 1'b1;
            return tx_irq_en;
        end
        return 1'b0;
    endfunction

    function automatic void rx_flush_apply();
        if (rx_flush)
        begin
            rx_head        = 0;
            rx_cnt         = 0;
            flags[FLAG_DR] = 1'b1;
        end
    endfunction

    function automatic void tx_flush_apply();
        if (tx_flush)
        begin
            tx_head = 0;
            tx_cnt  = 0;
        end
    endfunction

    // One event through the predicted FIFO core
    task automatic compute_event_result(input op_t op, input logic [7:0] bv,
                                        input logic [3:0] wf,
                                        output fifo_event_result_t r);
        int         rxt;
        int         txt;
        logic [3:0] cond;
        r   = '0;
        rxt = rx_trig_tbl[rx_trig_sel];
        txt = tx_trig_tbl[tx_trig_sel];
        case (op)
            OP_LINE_RX:
            begin
                // full queue drops the byte
                if (rx_cnt < FIFO_DEPTH)
                begin
                    rx_mem[(rx_head + rx_cnt) % FIFO_DEPTH] = bv;
                    rx_cnt++;
                end
                if (rx_cnt >= rxt)
                    flags[FLAG_DR] = 1'b0;
                rx_flush_apply();
                r.rx_irq = rx_level_check();
            end
            OP_LINE_READY:
            begin
                tx_flush_apply();
                if (tx_cnt > 0)
                begin
                    r.line_valid = 1'b1;
                    r.line_byte  = tx_mem[tx_head];
                    tx_head      = (tx_head + 1) % FIFO_DEPTH;
                    tx_cnt--;
                    r.tx_irq     = tx_level_check();
                end
                else
                begin
                    flags[FLAG_TEND] = 1'b1;
                end
            end
            OP_TX_WRITE:
            begin
                if (tx_cnt < FIFO_DEPTH)
                begin
                    tx_mem[(tx_head + tx_cnt) % FIFO_DEPTH] = bv;
                    tx_cnt++;
                end
            end
            OP_RX_READ:
            begin
                // empty read returns zero and changes nothing
                if (rx_cnt > 0)
                begin
                    r.read_byte = rx_mem[rx_head];
                    rx_head     = (rx_head + 1) % FIFO_DEPTH;
                    rx_cnt--;
                    if (rx_cnt >= rxt)
                    begin
                        flags[FLAG_DR]      = 1'b1;
                        read_marks[FLAG_DR] = 1'b0;
                    end
                end
            end
            OP_STAT_READ:
            begin
                read_marks = read_marks | flags;
            end
            OP_STAT_WRITE:
            begin
                // a cleared flag seen set by a read holds while its condition holds
                cond[FLAG_TEND] = (tx_cnt == 0);
                cond[FLAG_DR]   = (rx_cnt < rxt);
                cond[FLAG_TDFE] = (tx_cnt <= txt);
                cond[FLAG_RDF]  = (rx_cnt >= rxt);
                flags = wf | (~wf & flags & read_marks & cond);
            end
            OP_COUNT_READ:
            begin
            end
            default:
            begin
                r.rx_irq = rx_level_check();
                r.tx_irq = tx_level_check();
                rx_flush_apply();
                tx_flush_apply();
                if (!tx_en)
                    flags[FLAG_TEND] = 1'b1;
            end
        endcase
        r.rx_level = 5'(rx_cnt);
        r.tx_level = 5'(tx_cnt);
        r.tend     = flags[FLAG_TEND];
        r.dr       = flags[FLAG_DR];
        r.tdfe     = flags[FLAG_TDFE];
        r.rdf      = flags[FLAG_RDF];
    endtask

    function automatic string field_diff(input string name, input logic [7:0] w,
                                         input logic [7:0] g);
        if (g !== w)
            return $sformatf(" %s exp %0h got %0h", name, w, g);
        return "";
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head     = 0;
            rx_cnt      = 0;
            tx_head     = 0;
            tx_cnt      = 0;
            flags       = '0;
            read_marks  = '0;
            tx_irq_en   = 1'b0;
            rx_irq_en   = 1'b0;
            tx_en       = 1'b0;
            rx_trig_sel = 2'd0;
            tx_trig_sel = 2'd0;
            rx_flush    = 1'b0;
            tx_flush    = 1'b0;
            awaited_results.delete();
            results_owed = 0;
        end
        else
        begin
            // register writes; unknown index ignored
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TX_IRQ_EN:   tx_irq_en   = cfg_data[0];
                    REG_RX_IRQ_EN:   rx_irq_en   = cfg_data[0];
                    REG_TX_EN:       tx_en       = cfg_data[0];
                    REG_RX_TRIG_SEL: rx_trig_sel = cfg_data[1:0];
                    REG_TX_TRIG_SEL: tx_trig_sel = cfg_data[1:0];
                    REG_RX_FIFO_RST: rx_flush    = cfg_data[0];
                    REG_TX_FIFO_RST: tx_flush    = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            // result side first, so a same-edge request cannot match itself
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                result_no++;
                if (awaited_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d arrived with none pending: %h",
                                 result_no, m_tdata);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    diff = {field_diff("read_byte", want.read_byte, got.read_byte),
                            field_diff("rx_level", want.rx_level, got.rx_level),
                            field_diff("tx_level", want.tx_level, got.tx_level),
                            field_diff("tend", want.tend, got.tend),
                            field_diff("dr", want.dr, got.dr),
                            field_diff("tdfe", want.tdfe, got.tdfe),
                            field_diff("rdf", want.rdf, got.rdf),
                            field_diff("line_valid", want.line_valid, got.line_valid),
                            field_diff("line_byte", want.line_byte, got.line_byte),
                            field_diff("rx_irq", want.rx_irq, got.rx_irq),
                            field_diff("tx_irq", want.tx_irq, got.tx_irq),
                            field_diff("pad", want.pad, got.pad)};
                    if (diff != "")
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result %0d wrong:%s", result_no, diff);
                    end
                end
            end

            // request side: predict and queue
            if (s_tvalid && s_tready)
            begin
                compute_event_result(op_t'(s_tuser), s_tdata[7:0], s_tdata[11:8], fresh);
                awaited_results.push_back(fresh);
            end
            results_owed = awaited_results.size();
        end
    end

endmodule

@@ tb/sv/uart_fifo_status_controller_test.sv @@
`timescale 1ns / 100ps

module uart_fifo_status_controller_test;

    import ufsc_pkg::*;

    localparam int              ITEM_TARGET = 1400;
    localparam int              CYCLE_LIMIT = 500000;
    localparam int              HOLD_CYCLES = 60;
    localparam logic [2:0]      REG_NONE    = 3'd7;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [IN_TDATA_W-1:0]      s_tdata;
    logic [IN_TUSER_W-1:0]      s_tuser;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [OUT_TDATA_W-1:0]     m_tdata;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int                         mismatch_count;
    int                         results_owed;
    int                         items_sent;
    int                         cycle_count = 0;
    bit                         idle_en;
    bit                         hold_req;

    always #5 clk = ~clk;

    uart_fifo_status_controller u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    uart_fifo_status_checker u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result sink: random stall bursts, plus the long hold on request
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 14);
            m_tready <= (hold_left == 0 && stall_left == 0);
            if (hold_left > 0)
                hold_left--;
            if (stall_left > 0)
                stall_left--;
        end
    end

    // One register write; returns on a fresh falling edge
    task automatic cfg_write(input logic [2:0] idx, input logic [1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one request, optionally after a gap; valid stays high on return
    task automatic offer_event(input op_t op, input logic [7:0] bv, input logic [3:0] wf);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, wf, bv};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic offer_random();
        offer_event(op_t'($urandom_range(0, 7)), 8'($urandom), 4'($urandom));
    endtask

    // Stop offering and wait for every pending result
    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Phase setup; alternates the trigger extremes
    task automatic configure_phase(input int phase);
        logic [1:0] rxs;
        logic [1:0] txs;
        rxs = 2'($urandom_range(0, 3));
        txs = 2'($urandom_range(0, 3));
        if (phase % 4 == 0)
        begin
            rxs = 2'd0;
            txs = 2'd0;
        end
        else if (phase % 4 == 1)
        begin
            rxs = 2'd3;
            txs = 2'd3;
        end
        // upper data bit on 1-bit registers must be masked
        cfg_write(REG_TX_IRQ_EN, 2'($urandom_range(0, 3)));
        cfg_write(REG_RX_IRQ_EN, 2'($urandom_range(0, 3)));
        cfg_write(REG_TX_EN, 2'($urandom_range(0, 3)));
        cfg_write(REG_RX_TRIG_SEL, rxs);
        cfg_write(REG_TX_TRIG_SEL, txs);
        cfg_write(REG_RX_FIFO_RST, {1'($urandom), 1'($urandom_range(0, 4) == 0)});
        cfg_write(REG_TX_FIFO_RST, {1'($urandom), 1'($urandom_range(0, 4) == 0)});
    endtask

    // Mostly well-formed fill/drain runs, some status handshakes, some noise
    task automatic run_sequence();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        case (kind)
            0:       n = $urandom_range(8, 20);
            4:       n = $urandom_range(4, 20);
            default: n = $urandom_range(1, 8);
        endcase
        case (kind)
            0, 1:
                repeat (n) offer_event(OP_LINE_RX, 8'($urandom), 4'($urandom));
            2, 3:
                repeat (n) offer_event(OP_RX_READ, 8'($urandom), 4'($urandom));
            4:
                repeat (n) offer_event(OP_TX_WRITE, 8'($urandom), 4'($urandom));
            5:
                repeat (n) offer_event(OP_LINE_READY, 8'($urandom), 4'($urandom));
            6:
            begin
                offer_event(OP_STAT_READ, 8'($urandom), 4'($urandom));
                offer_event(OP_STAT_WRITE, 8'($urandom),
                            ($urandom_range(0, 1) == 0) ? 4'h0 : 4'($urandom));
            end
            7:
                offer_event(($urandom_range(0, 1) == 0) ? OP_RECHECK : OP_COUNT_READ,
                            8'($urandom), 4'($urandom));
            default:
                repeat ($urandom_range(1, 4)) offer_random();
        endcase
    endtask

    initial
    begin : stimulus
        int phase;
        int phase_end;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        idle_en    = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed: empty queues, flag hold on write of zero, pops, recheck
        offer_event(OP_COUNT_READ, 8'h00, 4'h0);
        offer_event(OP_RX_READ, 8'h00, 4'h0);
        offer_event(OP_LINE_READY, 8'h00, 4'h0);
        offer_event(OP_STAT_READ, 8'h00, 4'h0);
        offer_event(OP_STAT_WRITE, 8'h00, 4'h0);
        offer_event(OP_LINE_RX, 8'h00, 4'h0);
        offer_event(OP_LINE_RX, 8'hFF, 4'hF);
        offer_event(OP_TX_WRITE, 8'hFF, 4'h0);
        offer_event(OP_TX_WRITE, 8'h00, 4'h0);
        offer_event(OP_STAT_READ, 8'h00, 4'h0);
        offer_event(OP_STAT_WRITE, 8'hAA, 4'hF);
        offer_event(OP_STAT_WRITE, 8'h55, 4'h0);
        offer_event(OP_LINE_READY, 8'h00, 4'h0);
        offer_event(OP_RX_READ, 8'h00, 4'h0);
        offer_event(OP_RECHECK, 8'h00, 4'h0);
        settle();

        // irqs on, transmitter on, highest trigger selects, stray index
        cfg_write(REG_TX_IRQ_EN, 2'd1);
        cfg_write(REG_RX_IRQ_EN, 2'd1);
        cfg_write(REG_TX_EN, 2'd1);
        cfg_write(REG_RX_TRIG_SEL, 2'd3);
        cfg_write(REG_TX_TRIG_SEL, 2'd3);
        cfg_write(REG_NONE, 2'd3);
        offer_event(OP_RECHECK, 8'h00, 4'h0);
        offer_event(OP_LINE_RX, 8'h5A, 4'h0);
        offer_event(OP_LINE_READY, 8'h00, 4'h0);
        settle();

        // FIFO reset holds flush both queues
        cfg_write(REG_RX_FIFO_RST, 2'd1);
        cfg_write(REG_TX_FIFO_RST, 2'd1);
        offer_event(OP_LINE_RX, 8'h11, 4'h0);
        offer_event(OP_TX_WRITE, 8'h22, 4'h0);
        offer_event(OP_LINE_READY, 8'h00, 4'h0);
        offer_event(OP_RECHECK, 8'h00, 4'h0);
        settle();
        cfg_write(REG_RX_FIFO_RST, 2'd0);
        cfg_write(REG_TX_FIFO_RST, 2'd0);

        // Random phases; idling off every third phase and near the end
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            idle_en = (items_sent < ITEM_TARGET - 200) && (phase % 3 != 2);
            configure_phase(phase);
            if (phase == 1)
            begin
                // long sink hold with back-to-back requests: input must back up
                idle_en  = 1'b0;
                hold_req = 1'b1;
                repeat (30) offer_random();
                idle_en  = 1'b1;
            end
            phase_end = items_sent + 100;
            while (items_sent < phase_end)
                run_sequence();
            phase++;
        end

        settle();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ uart_fifo_status_controller.f @@
+incdir+design
design/ufsc_pkg.sv
design/ufsc_ctrl.sv
design/ufsc_datapath.sv
design/uart_fifo_status_controller.sv
design/ufsc_checker.sv
tb/sv/uart_fifo_status_checker.sv
tb/sv/uart_fifo_status_controller_test.sv
